/* rtl/core/utf8d_pkg.sv */
`default_nettype none

package utf8d_pkg;

  // Field widths fixed by the interface
  localparam int BYTE_W = 8;
  localparam int CP_W   = 31;
  localparam int IDX_W  = 32;
  localparam int PEND_W = 3;

  // Default width of the character counter
  localparam int COUNT_WIDTH_DEF = 32;

  // Byte classes and masks
  localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;
  localparam logic [CP_W-1:0]   REPL_CHAR = 31'h0000FFFD;

  // Item held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;
  } in_item_t;

  // Result item handed to the output register
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [IDX_W-1:0] char_index;
    logic             replaced;
    logic             end_of_string;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/utf8d_in_stage.sv */
`default_nettype none

module utf8d_in_stage
  import utf8d_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              final_byte,
  input  wire logic              advance,
  output logic                   item_valid,
  output in_item_t               item
);

  logic load_en;

  // Register refills when empty or when its item moves on
  assign load_en  = !item_valid || advance;
  assign in_stall = !load_en;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load_en) begin
      item_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load_en) begin
      item.data_byte  <= data_byte;
      item.final_byte <= final_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utf8d_decode.sv */
`default_nettype none

module utf8d_decode
  import utf8d_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire in_item_t item,
  input  wire logic     advance,
  output logic          res_valid,
  output result_t       res
);

  logic [PEND_W-1:0]      bytes_pending, bytes_pending_next;
  logic [CP_W-1:0]        accumulator, accumulator_next;
  logic [COUNT_WIDTH-1:0] char_counter, char_counter_next;

  logic [BYTE_W-1:0] b;
  logic              fin;
  logic [CP_W-1:0]   acc_shift;
  logic [PEND_W-1:0] pend_dec;
  logic [IDX_W-1:0]  idx;
  logic              emit;
  logic              term;
  logic              rep;
  logic [CP_W-1:0]   cp;
  logic [PEND_W-1:0] lead_pend;
  logic [BYTE_W-1:0] lead_mask;

  assign b   = item.data_byte;
  assign fin = item.final_byte;

  // Index from the low bits of the counter, zero-extended when the counter is narrower
  generate
    if (COUNT_WIDTH >= IDX_W) begin : g_idx_trunc
      assign idx = char_counter[IDX_W-1:0];
    end else begin : g_idx_ext
      assign idx = {{(IDX_W-COUNT_WIDTH){1'b0}}, char_counter};
    end
  endgenerate

  // Continuation step
  assign acc_shift = {accumulator[CP_W-7:0], 6'b0} | {{(CP_W-BYTE_W){1'b0}}, b & CONT_MASK};
  assign pend_dec  = bytes_pending - PEND_W'(1);

  // Lead byte length and payload mask
  always_comb begin
    lead_pend = '0;
    lead_mask = '0;
    if (b inside {[8'hC0:8'hDF]}) begin
      lead_pend = PEND_W'(1);
      lead_mask = 8'h1F;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      lead_pend = PEND_W'(2);
      lead_mask = 8'h0F;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      lead_pend = PEND_W'(3);
      lead_mask = 8'h07;
    end else if (b inside {[8'hF8:8'hFB]}) begin
      lead_pend = PEND_W'(4);
      lead_mask = 8'h03;
    end else if (b inside {[8'hFC:8'hFD]}) begin
      lead_pend = PEND_W'(5);
      lead_mask = 8'h01;
    end
  end

  // Decode and next state
  always_comb begin
    emit               = 1'b0;
    term               = 1'b0;
    rep                = 1'b0;
    cp                 = '0;
    bytes_pending_next = bytes_pending;
    accumulator_next   = accumulator;
    char_counter_next  = char_counter;
    if (bytes_pending == '0) begin
      if (b == NUL_BYTE) begin
        term = 1'b1;
        emit = 1'b1;
      end else if (b < 8'h80) begin
        emit = 1'b1;
        cp   = {{(CP_W-BYTE_W){1'b0}}, b};
      end else if (lead_pend == '0) begin
        // Stray continuation or 0xFE/0xFF
        emit = 1'b1;
        rep  = 1'b1;
        cp   = REPL_CHAR;
      end else if (fin) begin
        // Lead byte cut off by the end mark
        emit = 1'b1;
        rep  = 1'b1;
        cp   = REPL_CHAR;
      end else begin
        bytes_pending_next = lead_pend;
        accumulator_next   = {{(CP_W-BYTE_W){1'b0}}, b & lead_mask};
      end
    end else begin
      if (pend_dec == '0) begin
        emit = 1'b1;
        cp   = acc_shift;
      end else if (fin) begin
        emit = 1'b1;
        rep  = 1'b1;
        cp   = REPL_CHAR;
      end else begin
        bytes_pending_next = pend_dec;
        accumulator_next   = acc_shift;
      end
    end
    if (emit) begin
      bytes_pending_next = '0;
      accumulator_next   = '0;
      char_counter_next  = char_counter + COUNT_WIDTH'(1);
    end
    // End of string clears everything
    if (term || (emit && fin)) begin
      char_counter_next = '0;
    end
  end

  assign res_valid         = item_valid && emit;
  assign res.code_point    = cp;
  assign res.char_index    = idx;
  assign res.replaced      = rep;
  assign res.end_of_string = term || fin;

  // String state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      accumulator   <= '0;
      char_counter  <= '0;
    end else if (item_valid && advance) begin
      bytes_pending <= bytes_pending_next;
      accumulator   <= accumulator_next;
      char_counter  <= char_counter_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utf8d_out_stage.sv */
`default_nettype none

module utf8d_out_stage
  import utf8d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_valid,
  input  wire result_t          res,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CP_W-1:0]       code_point,
  output logic [IDX_W-1:0]      char_index,
  output logic                  replaced,
  output logic                  end_of_string
);

  result_t held;

  // Slot is free when empty or when its item is being taken
  assign advance = !out_valid || !out_stall;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      held <= res;
    end
  end

  assign code_point    = held.code_point;
  assign char_index    = held.char_index;
  assign replaced      = held.replaced;
  assign end_of_string = held.end_of_string;

endmodule

`default_nettype wire

/* rtl/core/utf8_to_codepoint_decoder.sv */
// UTF-8 byte stream to code point decoder.
// A byte is accepted into the input register and its result is then registered in the output register.
// Throughput: one byte per cycle while the receiver does not stall; the decode and state
// update for a byte take place between the input register and the output register.
// Reset: synchronous, active high; clears both valid bits and the string state.
`default_nettype none

module utf8_to_codepoint_decoder
  import utf8d_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              final_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CP_W-1:0]        code_point,
  output logic [IDX_W-1:0]       char_index,
  output logic                   replaced,
  output logic                   end_of_string
);

  logic     advance;
  logic     item_valid;
  in_item_t item;
  logic     res_valid;
  result_t  res;

  // Input register
  utf8d_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Decode with string state
  utf8d_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dec (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register
  utf8d_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .char_index    (char_index),
    .replaced      (replaced),
    .end_of_string (end_of_string)
  );

endmodule

`default_nettype wire

/* tb/sv/utf8_to_codepoint_decoder_test.sv */
`default_nettype none

module utf8_to_codepoint_decoder_test;
  import utf8d_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RST_CYCLES   = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 6;
  localparam int RUN_LIMIT    = 20 * 500_000;

  // Byte classes used when building strings and predicting results
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_BAD  = 8'hFE;
  localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              final_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CP_W-1:0]   code_point;
  logic [IDX_W-1:0]  char_index;
  logic              replaced;
  logic              end_of_string;

  // Decoder state as predicted
  logic [PEND_W-1:0] pend_cnt = '0;
  logic [CP_W-1:0]   acc_bits = '0;
  logic [IDX_W-1:0]  char_cnt = '0;

  result_t expected_points[$];

  // Idle controls and receiver hold-off request
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  int fail_count = 0;
  int bytes_sent = 0;
  int points_seen = 0;
  int repl_seen = 0;
  int ends_seen = 0;

  utf8_to_codepoint_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_point   (code_point),
    .char_index   (char_index),
    .replaced     (replaced),
    .end_of_string(end_of_string)
  );

  always #(CLK_HALF) clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Predict the result of one accepted byte; returns 1 when a code point comes out
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                     output result_t r);
    int ones;
    logic [CP_W-1:0] cp;
    bit rep;
    r = '0;
    cp = '0;
    rep = 1'b0;
    if (pend_cnt == 0) begin
      // terminator: count goes out, string state clears
      if (b == NUL_BYTE) begin
        r.char_index = char_cnt;
        r.end_of_string = 1'b1;
        pend_cnt = '0;
        acc_bits = '0;
        char_cnt = '0;
        return 1'b1;
      end
      if (b <= ASCII_MAX) begin
        cp = CP_W'(b);
      end else if (b < LEAD_MIN || b >= LEAD_BAD) begin
        cp = REPL_CHAR;
        rep = 1'b1;
      end else begin
        ones = 0;
        while (ones < 7 && b[7-ones]) ones++;
        pend_cnt = PEND_W'(ones - 1);
        acc_bits = CP_W'(b & (8'h7F >> ones));
        if (!fin) return 1'b0;
        cp = REPL_CHAR;
        rep = 1'b1;
      end
    end else begin
      // continuation: tag bits ignored
      acc_bits = {acc_bits[CP_W-7:0], b[5:0]};
      pend_cnt = pend_cnt - 1'b1;
      if (pend_cnt == 0) begin
        cp = acc_bits;
      end else if (fin) begin
        cp = REPL_CHAR;
        rep = 1'b1;
      end else begin
        return 1'b0;
      end
    end
    r.code_point = cp;
    r.char_index = char_cnt;
    r.replaced = rep;
    r.end_of_string = fin;
    pend_cnt = '0;
    acc_bits = '0;
    char_cnt = fin ? '0 : char_cnt + 1'b1;
    return 1'b1;
  endfunction

  // Offer one item, wait for acceptance, record its prediction
  task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic fin);
    int gap;
    result_t r;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (decode_byte(b, fin, r)) expected_points = {expected_points, r};
  endtask

  // Build one string of random characters, mostly well formed, and feed it
  task automatic feed_string(input int n_chars);
    logic [BYTE_W-1:0] q[$];
    int kind, len;
    logic [BYTE_W-1:0] lead;
    bit by_nul;
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 8 || kind == 19) begin
        q = {q, BYTE_W'($urandom_range(1, 127))};
      end else if (kind < 17) begin
        len = (kind < 12) ? 2 : (kind < 14) ? 3 : (kind < 15) ? 4 : $urandom_range(5, 6);
        lead = (8'hFF << (8 - len)) | (BYTE_W'($urandom) & (8'h7F >> len));
        q = {q, lead};
        // rarely cut short, rarely a bad tag
        if ($urandom_range(0, 24) == 0) len = $urandom_range(1, len - 1);
        for (int k = 1; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) q = {q, BYTE_W'($urandom)};
          else q = {q, CONT_TAG | (BYTE_W'($urandom) & CONT_MASK)};
        end
      end else if (kind == 17) begin
        q = {q, CONT_TAG | (BYTE_W'($urandom) & CONT_MASK)};
      end else begin
        q = {q, ($urandom_range(0, 1) ? 8'hFE : 8'hFF)};
      end
    end
    by_nul = ($urandom_range(0, 2) == 0);
    if (by_nul) begin
      q = {q, NUL_BYTE};
    end else if ($urandom_range(0, 7) == 0 || q.size() == 0) begin
      // string ends inside a multibyte character
      len = $urandom_range(2, 6);
      q = {q, (8'hFF << (8 - len)) | (BYTE_W'($urandom) & (8'h7F >> len))};
      repeat ($urandom_range(0, len - 2))
        q = {q, CONT_TAG | (BYTE_W'($urandom) & CONT_MASK)};
    end
    foreach (q[i]) feed_byte(q[i], (i == q.size() - 1) ? (!by_nul || $urandom_range(0, 1)) : 1'b0);
  endtask

  // Receiver stall: random idles, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      stall_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_length() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted code point with the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      points_seen++;
      if (replaced) repl_seen++;
      if (end_of_string) ends_seen++;
      if (expected_points.size() == 0) begin
        $error("unexpected result: code_point %h char_index %0d", code_point, char_index);
        fail_count++;
      end else begin
        e = expected_points.pop_front();
        if (code_point !== e.code_point) begin
          $error("code_point: expected %h, actual %h", e.code_point, code_point);
          fail_count++;
        end
        if (char_index !== e.char_index) begin
          $error("char_index: expected %0d, actual %0d", e.char_index, char_index);
          fail_count++;
        end
        if (replaced !== e.replaced) begin
          $error("replaced: expected %b, actual %b", e.replaced, replaced);
          fail_count++;
        end
        if (end_of_string !== e.end_of_string) begin
          $error("end_of_string: expected %b, actual %b", e.end_of_string, end_of_string);
          fail_count++;
        end
      end
    end
  end

  // Field extremes and each malformed case, no idling
  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    feed_byte(8'h41, 1'b0); feed_byte(8'h7F, 1'b0);                 // ASCII
    feed_byte(8'h80, 1'b0); feed_byte(8'hBF, 1'b0);                 // stray continuation
    feed_byte(8'hC0, 1'b0); feed_byte(8'h80, 1'b0);                 // smallest two-byte
    feed_byte(8'hF0, 1'b0); feed_byte(8'h9F, 1'b0);
    feed_byte(8'h98, 1'b0); feed_byte(8'h80, 1'b0);                 // four-byte
    feed_byte(8'hFD, 1'b0);
    repeat (5) feed_byte(8'hBF, 1'b0);                              // six-byte, all ones
    feed_byte(8'hFE, 1'b0); feed_byte(8'hFF, 1'b0);                 // invalid leads
    feed_byte(8'hC2, 1'b0); feed_byte(NUL_BYTE, 1'b0);              // NUL as continuation
    feed_byte(NUL_BYTE, 1'b0);                                      // terminator
    feed_byte(8'hE2, 1'b0); feed_byte(8'h82, 1'b1);                 // truncated by end mark
    feed_byte(8'hC3, 1'b1);                                         // lead with end mark
    feed_byte(8'h41, 1'b1);                                         // end mark on a char
    feed_byte(NUL_BYTE, 1'b1);                                      // empty string, both ends
  endtask

  // Random strings with idling on both sides
  task automatic test_random_strings();
    int start;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < 400) feed_string($urandom_range(1, 12));
  endtask

  // Random strings at full rate
  task automatic test_back_to_back();
    int start;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    start = bytes_sent;
    while (bytes_sent - start < 100) feed_string($urandom_range(1, 12));
  endtask

  // Raw random bytes and end marks
  task automatic test_noise();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (80) feed_byte(BYTE_W'($urandom), $urandom_range(0, 11) == 0);
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_long_stall();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req <= ~hold_req;
    repeat (4) feed_string($urandom_range(4, 10));
    rx_idle_on = 1'b1;
  endtask

  initial begin
    int waited;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_strings();
    test_back_to_back();
    test_noise();
    test_long_stall();
    in_valid <= 1'b0;
    final_byte <= 1'b0;
    waited = 0;
    while (expected_points.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_points.size() > 0) begin
      $error("%0d predicted code points never came out", expected_points.size());
      fail_count++;
    end
    $display("Fed %0d bytes; checked %0d code points, %0d replacements, %0d string ends",
             bytes_sent, points_seen, repl_seen, ends_seen);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_in_stage.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8d_out_stage.sv
rtl/core/utf8_to_codepoint_decoder.sv
tb/sv/utf8_to_codepoint_decoder_test.sv
